@@ rtl/cc20_pkg.sv @@
// Package: ChaCha20 stream cipher types, constants and helper functions.
package cc20_pkg;

    localparam int DOUBLE_ROUNDS = 10;
    localparam int NUM_WORDS     = 16;
    localparam int NUM_STEPS     = 2 * DOUBLE_ROUNDS;
    localparam int STEP_W        = $clog2(NUM_STEPS + 1);

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_NONL  = 3'd4;
    localparam logic [2:0] REG_NONH  = 3'd5;
    localparam logic [2:0] REG_START = 3'd6;

    typedef logic [31:0] word_t;

    typedef struct packed {
        logic [31:0] data_in;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data_out;
        logic [2:0]  byte_count_out;
        logic        last_out;
    } out_item_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    function automatic word_t rotl(input word_t v, input int n);
        rotl = (v << n) | (v >> (32 - n));
    endfunction

    function automatic quad_t quarter_round(input quad_t q);
        word_t a, b, c, d;
        a = q.a; b = q.b; c = q.c; d = q.d;
        a = a + b; d = rotl(d ^ a, 16);
        c = c + d; b = rotl(b ^ c, 12);
        a = a + b; d = rotl(d ^ a, 8);
        c = c + d; b = rotl(b ^ c, 7);
        quarter_round = '{a: a, b: b, c: c, d: d};
    endfunction

endpackage

@@ rtl/cc20_qr_cell.sv @@
// Quarter-round cell: holds one state column; runs one quarter round a cycle while run is high.
module cc20_qr_cell (
    input  logic               aclk,
    input  logic               load,
    input  logic               run,
    input  cc20_pkg::quad_t    init_col,
    input  cc20_pkg::quad_t    from_nbr,
    output cc20_pkg::quad_t    col_out,
    output cc20_pkg::quad_t    qr_out
);
    import cc20_pkg::*;

    quad_t col_reg;

    assign col_out = col_reg;
    assign qr_out  = quarter_round(col_reg);

    // Load takes the fresh column; run takes the rerouted column handed in by the row.
    always_ff @(posedge aclk) begin
        if (load) begin
            col_reg <= init_col;
        end else if (run) begin
            col_reg <= from_nbr;
        end
    end
endmodule

@@ rtl/cc20_core.sv @@
// Keystream core: a row of four quarter-round cells, alternating column and diagonal steps.
module cc20_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [511:0]         init_state,
    output logic                 busy,
    output logic                 done,
    output logic [511:0]         keystream
);
    import cc20_pkg::*;

    quad_t init_col [4];
    quad_t col_q    [4];
    quad_t qr_q     [4];
    quad_t nbr      [4];
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [511:0]      init_reg;
    logic              diag;

    function automatic word_t iw(input logic [511:0] s, input int i);
        iw = s[32*i +: 32];
    endfunction

    assign diag = step_reg[0];

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_cell
            assign init_col[g] = '{a: iw(init_state, g), b: iw(init_state, 4 + g),
                                   c: iw(init_state, 8 + g), d: iw(init_state, 12 + g)};
            cc20_qr_cell u_cell (
                .aclk     (aclk),
                .load     (start),
                .run      (busy_reg),
                .init_col (init_col[g]),
                .from_nbr (nbr[g]),
                .col_out  (col_q[g]),
                .qr_out   (qr_q[g])
            );
        end
    endgenerate

    // Cell g holds column g in column steps and the diagonal starting at row-0 word g
    // in diagonal steps; the b, c, d rows shift between the cells between the two.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nbr[i].a = qr_q[i].a;
            if (!diag) begin
                nbr[i].b = qr_q[(i + 1) % 4].b;
                nbr[i].c = qr_q[(i + 2) % 4].c;
                nbr[i].d = qr_q[(i + 3) % 4].d;
            end else begin
                nbr[i].b = qr_q[(i + 3) % 4].b;
                nbr[i].c = qr_q[(i + 2) % 4].c;
                nbr[i].d = qr_q[(i + 1) % 4].d;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            keystream[32*i      +: 32] = col_q[i].a + iw(init_reg, i);
            keystream[32*(4+i)  +: 32] = col_q[i].b + iw(init_reg, 4 + i);
            keystream[32*(8+i)  +: 32] = col_q[i].c + iw(init_reg, 8 + i);
            keystream[32*(12+i) +: 32] = col_q[i].d + iw(init_reg, 12 + i);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            init_reg <= init_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                if (step_reg == STEP_W'(NUM_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    step_reg <= '0;
                end else begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg < STEP_W'(NUM_STEPS)) else $error("step out of range");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(done_reg && busy_reg)) else $error("done while busy");
endmodule

@@ rtl/chacha20_stream_cipher.sv @@
// Top level: ChaCha20 stream cipher, one 32-bit word per request.
//
// Usage: write key, nonce and start counter on the cfg channel (index 0..6) while idle.
// Stream message words on s_ (data, byte count 1..4, last flag); each request returns
// one m_ request with data XOR keystream, unused bytes zero, and the same count and last.
// A keystream block is made at word position zero of each 16-word block: the core's
// four quarter-round cells take one column or diagonal step per cycle for 10 double
// rounds, and the final add is combinational; no request is taken while a block is
// under way, and the other 15 words of the block use the stored keystream.
// A one-entry output register holds the result; the next request is taken only when
// it is empty or being read, so the block stalls while the output is still full and
// the receiver holds m_ready low. Reset (aresetn low, synchronous) clears the config
// and control registers to zero and opens the next message at the start counter. The
// last flag restarts the counter and word position for the next message.
module chacha20_stream_cipher (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cc20_pkg::in_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cc20_pkg::out_item_t   m_data
);
    import cc20_pkg::*;

    logic [63:0] key0_reg, key1_reg, key2_reg, key3_reg, nonl_reg;
    logic [31:0] nonh_reg, start_reg;
    logic [31:0] ctr_reg;
    logic [3:0]  pos_reg;
    logic        open_reg;
    logic [511:0] ks_reg;
    logic        wait_reg;
    in_item_t    hold_reg;
    logic        mv_reg;
    out_item_t   mo_reg;

    logic        core_start, core_busy, core_done;
    logic [511:0] core_ks, init_state;
    logic [31:0] cur_ctr;
    logic [3:0]  cur_pos;
    logic        out_free;
    logic        emit;
    in_item_t    emit_item;
    logic [3:0]  emit_pos;
    logic [31:0] emit_ks, mask;
    logic [2:0]  cnt;
    logic [511:0] ks_src;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key0_reg <= '0; key1_reg <= '0; key2_reg <= '0; key3_reg <= '0;
            nonl_reg <= '0; nonh_reg <= '0; start_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_KEY0:  key0_reg  <= cfg_data;
                REG_KEY1:  key1_reg  <= cfg_data;
                REG_KEY2:  key2_reg  <= cfg_data;
                REG_KEY3:  key3_reg  <= cfg_data;
                REG_NONL:  nonl_reg  <= cfg_data;
                REG_NONH:  nonh_reg  <= cfg_data[31:0];
                REG_START: start_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Counter and position seen by the incoming word, after a message restart.
    assign cur_ctr = open_reg ? ctr_reg : start_reg;
    assign cur_pos = open_reg ? pos_reg : 4'd0;

    assign init_state = {nonh_reg, nonl_reg, cur_ctr, key3_reg, key2_reg, key1_reg, key0_reg,
                         SIGMA3, SIGMA2, SIGMA1, SIGMA0};

    assign out_free = !mv_reg || m_ready;
    // Accept only while no block is under way and the output can take a word.
    assign s_ready = !wait_reg && !core_busy && !core_done && out_free;
    assign core_start = s_valid && s_ready && (cur_pos == 4'd0);

    // Emit either a word that needs no new block, or the held word once its block is ready.
    always_comb begin
        emit      = 1'b0;
        emit_item = s_data;
        emit_pos  = cur_pos;
        ks_src    = ks_reg;
        if (core_done) begin
            emit      = 1'b1;
            emit_item = hold_reg;
            emit_pos  = 4'd0;
            ks_src    = core_ks;
        end else if (s_valid && s_ready && cur_pos != 4'd0) begin
            emit = 1'b1;
        end
        emit_ks = ks_src[32*emit_pos +: 32];
        cnt = (emit_item.byte_count == 3'd0 || emit_item.byte_count > 3'd4)
              ? 3'd4 : emit_item.byte_count;
        case (cnt)
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    cc20_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (core_start),
        .init_state (init_state),
        .busy       (core_busy),
        .done       (core_done),
        .keystream  (core_ks)
    );

    always_ff @(posedge aclk) begin
        if (core_done) begin
            ks_reg <= core_ks;
        end
        if (core_start) begin
            hold_reg <= s_data;
        end
        if (emit) begin
            mo_reg <= '{data_out: (emit_item.data_in ^ emit_ks) & mask,
                        byte_count_out: cnt, last_out: emit_item.last_word};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg  <= '0;
            pos_reg  <= '0;
            open_reg <= 1'b0;
            wait_reg <= 1'b0;
            mv_reg   <= 1'b0;
        end else begin
            if (emit) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            if (core_start) begin
                wait_reg <= 1'b1;
            end else if (core_done) begin
                wait_reg <= 1'b0;
            end
            // Advance position and counter at accept time.
            if (s_valid && s_ready) begin
                if (s_data.last_word) begin
                    open_reg <= 1'b0;
                    pos_reg  <= '0;
                    ctr_reg  <= cur_ctr + ((cur_pos == 4'd15) ? 32'd1 : 32'd0);
                end else begin
                    open_reg <= 1'b1;
                    pos_reg  <= cur_pos + 4'd1;
                    ctr_reg  <= cur_ctr + ((cur_pos == 4'd15) ? 32'd1 : 32'd0);
                end
            end
        end
    end

    assign m_valid = mv_reg;
    assign m_data  = mo_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |-> !emit) else $error("output overwritten");
    a_done_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        core_done |-> wait_reg) else $error("block done with no held word");
    a_no_accept_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_reg |-> !s_ready) else $error("accept during block");
endmodule

@@ test/chacha20_stream_cipher_tb.sv @@
// Testbench for the ChaCha20 stream cipher: directed and random messages checked against a predictor.
module chacha20_stream_cipher_tb;
    import cc20_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    chacha20_stream_cipher DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #6 aclk = ~aclk;

    // Predictor copy of the key schedule and stream position
    logic [63:0] key_q [4];
    logic [63:0] nonce_lo_q;
    logic [31:0] nonce_hi_q;
    logic [31:0] start_ctr_q;
    logic [31:0] blk_ctr;
    logic [3:0]  word_pos;
    logic [31:0] ks_block [16];
    bit          msg_open;

    out_item_t cipher_q [$];
    int        fail_count = 0;
    int        cycles = 0;
    bit        idle_off = 0;   // set to run a stretch with no idling on either side

    function automatic logic [31:0] rot(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic qround(inout logic [31:0] x [16], input int a, b, c, d);
        x[a] += x[b]; x[d] = rot(x[d] ^ x[a], 16);
        x[c] += x[d]; x[b] = rot(x[b] ^ x[c], 12);
        x[a] += x[b]; x[d] = rot(x[d] ^ x[a], 8);
        x[c] += x[d]; x[b] = rot(x[b] ^ x[c], 7);
    endtask

    task automatic build_keystream();
        logic [31:0] init [16];
        logic [31:0] x [16];
        init[0] = 32'h61707865; init[1] = 32'h3320646e;
        init[2] = 32'h79622d32; init[3] = 32'h6b206574;
        for (int k = 0; k < 4; k++) begin
            init[4 + 2 * k] = key_q[k][31:0];
            init[5 + 2 * k] = key_q[k][63:32];
        end
        init[12] = blk_ctr;
        init[13] = nonce_lo_q[31:0];
        init[14] = nonce_lo_q[63:32];
        init[15] = nonce_hi_q;
        x = init;
        for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
            qround(x, 0, 4, 8, 12); qround(x, 1, 5, 9, 13);
            qround(x, 2, 6, 10, 14); qround(x, 3, 7, 11, 15);
            qround(x, 0, 5, 10, 15); qround(x, 1, 6, 11, 12);
            qround(x, 2, 7, 8, 13); qround(x, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) ks_block[i] = x[i] + init[i];
    endtask

    // Advance the predictor by one accepted request and queue its expected cipher word
    task automatic predict_cipher(in_item_t it);
        out_item_t   exp_item;
        logic [2:0]  cnt;
        logic [31:0] mask;
        cnt = it.byte_count;
        if (cnt == 3'd0 || cnt > 3'd4) cnt = 3'd4;
        if (!msg_open) begin
            blk_ctr = start_ctr_q;
            word_pos = '0;
            msg_open = 1;
        end
        if (word_pos == 4'd0) build_keystream();
        mask = (cnt == 3'd4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * cnt)) - 32'd1);
        exp_item.data_out = (it.data_in ^ ks_block[word_pos]) & mask;
        exp_item.byte_count_out = cnt;
        exp_item.last_out = it.last_word;
        cipher_q.push_back(exp_item);
        word_pos = word_pos + 4'd1;
        if (word_pos == 4'd0) blk_ctr = blk_ctr + 32'd1;
        if (it.last_word) begin
            msg_open = 0;
            word_pos = '0;
        end
    endtask

    function automatic bit idle_now();
        return !idle_off && ($urandom_range(99) < 28);
    endfunction

    // Write one register; the predictor drops unknown indexes like the block does.
    // With more set, hold valid high for a write that follows at once.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val, bit more = 1'b0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (!more) cfg_valid <= 1'b0;
        case (idx)
            REG_KEY0:  key_q[0] = val;
            REG_KEY1:  key_q[1] = val;
            REG_KEY2:  key_q[2] = val;
            REG_KEY3:  key_q[3] = val;
            REG_NONL:  nonce_lo_q = val;
            REG_NONH:  nonce_hi_q = val[31:0];
            REG_START: start_ctr_q = val[31:0];
            default: ;
        endcase
    endtask

    // Send one request: idle at random first, then hold valid until accepted.
    // Valid stays high after the accept; whoever idles next drops it.
    task automatic send_word(logic [31:0] d, logic [2:0] cnt, logic last);
        in_item_t it;
        it.data_in = d; it.byte_count = cnt; it.last_word = last;
        if (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (idle_now()) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        predict_cipher(it);
    endtask

    // Wait until every expected word has come back, then let the block settle
    task automatic drain();
        s_valid <= 1'b0;
        while (cipher_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_config(logic [63:0] k0, k1, k2, k3, nl, logic [31:0] nh, sc);
        write_reg(REG_KEY0, k0, 1'b1); write_reg(REG_KEY1, k1, 1'b1);
        write_reg(REG_KEY2, k2, 1'b1); write_reg(REG_KEY3, k3, 1'b1);
        write_reg(REG_NONL, nl, 1'b1); write_reg(REG_NONH, {32'h0, nh}, 1'b1);
        write_reg(REG_START, {32'h0, sc}, 1'b0);
    endtask

    task automatic send_message(int len);
        logic [2:0] cnt;
        for (int i = 0; i < len; i++) begin
            cnt = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'd4;
            send_word($urandom, cnt, i == len - 1);
        end
    endtask

    // Known-answer style block: sequential key, RFC nonce, counter one
    task automatic test_rfc_vector();
        set_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
                   64'h1f1e1d1c1b1a1918, 64'h4a00000000000000, 32'h0, 32'd1);
        for (int i = 0; i < 17; i++) send_word(32'h0, 3'd4, i == 16);
        drain();
    endtask

    // Field extremes, every byte count including out-of-range ones, single-word message
    task automatic test_field_extremes();
        logic [2:0] cnt;
        set_config('1, '1, '1, '1, '1, '1, 32'hFFFF_FFFF);
        for (int c = 0; c < 8; c++) begin
            cnt = 3'(c);
            send_word(c[0] ? 32'hFFFF_FFFF : 32'h0, cnt, 1'b0);
        end
        send_word(32'hA5A5_5A5A, 3'd2, 1'b1);
        send_word(32'h1234_5678, 3'd4, 1'b1);
        drain();
    endtask

    // Counter wrap across the 2^32 boundary, then random messages under several configs
    task automatic test_random_messages();
        set_config(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 32'hFFFF_FFFF);
        send_message(40);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_UNUSED, {$urandom, $urandom}, 1'b1);
            set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                       (ph == 1) ? 32'h0 : $urandom);
            idle_off = (ph == 2);
            for (int m = 0; m < 6; m++) begin
                send_message($urandom_range(1, 20));
                if (m == 3) begin
                    s_valid <= 1'b0;
                    while (cipher_q.size() != 0) @(posedge aclk);
                end
            end
            drain();
        end
        idle_off = 0;
    endtask

    // Receiver: random stall, compare each returned word with the oldest expectation
    always @(posedge aclk) begin
        out_item_t exp_item;
        if (aresetn && m_valid && m_ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t unexpected word: actual %h", $time, m_data);
                fail_count++;
            end else begin
                exp_item = cipher_q.pop_front();
                if (m_data.data_out !== exp_item.data_out) begin
                    $display("%0t data_out: expected %h actual %h", $time,
                             exp_item.data_out, m_data.data_out);
                    fail_count++;
                end
                if (m_data.byte_count_out !== exp_item.byte_count_out) begin
                    $display("%0t byte_count_out: expected %0d actual %0d", $time,
                             exp_item.byte_count_out, m_data.byte_count_out);
                    fail_count++;
                end
                if (m_data.last_out !== exp_item.last_out) begin
                    $display("%0t last_out: expected %0d actual %0d", $time,
                             exp_item.last_out, m_data.last_out);
                    fail_count++;
                end
            end
        end
        m_ready <= !idle_now();
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 4; k++) key_q[k] = '0;
        nonce_lo_q = '0; nonce_hi_q = '0; start_ctr_q = '0;
        blk_ctr = '0; word_pos = '0; msg_open = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_rfc_vector();
        test_field_extremes();
        test_random_messages();
        if (fail_count == 0 && cipher_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
